// ===== hw/rtl/sgt_pkg.sv =====
// ---------------------------------------------------------------------------
// Sequence gap tracker package
// Table sizing, sequencer states and the control and status bundles that
// pass between the sequencer and the datapath.
// ---------------------------------------------------------------------------
package sgt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int DATA_W        = 32;
   localparam int ENTRY_W       = 2 * DATA_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } sgt_state_type;

   // Sequencer commands to the datapath.
   typedef struct packed {
      logic             capture;
      logic             ram_re;
      logic             ram_we;
      logic [IDX_W-1:0] ram_addr;
      logic             load_out;
      logic             hit;
      logic             full;
   } sgt_ctrl_type;

   // Datapath status back to the sequencer.
   typedef struct packed {
      logic match;
      logic out_free;
   } sgt_status_type;

endpackage

// ===== hw/rtl/sampler_sequence_gap_tracker.sv =====
// ---------------------------------------------------------------------------
// Sampler sequence gap tracker
// Per-sampler table of last sequence numbers with drop counting.
// ---------------------------------------------------------------------------
// Each request transaction names a sampler and its sequence number, and
// gives exactly one response transaction: the number of samples missed
// since that sampler's previous packet (new minus last minus one, modulo
// 2^32), or zero with new_sampler set when the sampler was not yet known.
// A new sampler takes the next free table entry; once all TABLE_ENTRIES
// entries are taken, further new samplers are reported with table_full set
// and are not stored. Entries are freed only by reset, which needs no
// clearing pass. The table RAM has one port; the scan reads one stored
// entry per cycle up to the first match, then the update waits until the
// output register is free. The block takes no new request while one is
// in progress; a finished response waits in its output register and a
// new request may be accepted meanwhile.
module sampler_sequence_gap_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [sgt_pkg::DATA_W-1:0] req_sampler_id,
   input  logic [sgt_pkg::DATA_W-1:0] req_seq_number,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sgt_pkg::DATA_W-1:0] rsp_dropped_count,
   output logic                      rsp_new_sampler,
   output logic                      rsp_table_full
);
   import sgt_pkg::*;

   sgt_ctrl_type      ctrl;
   sgt_status_type    status;
   logic [DATA_W-1:0] id_ff;
   logic [DATA_W-1:0] seq_ff;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [DATA_W-1:0] dropped;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] dropped_ff;
   logic              new_ff;
   logic              full_ff;

   sgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Entry layout: sampler identifier in the upper half, last sequence below.
   sgt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ctrl.ram_we),
      .re    (ctrl.ram_re),
      .addr  (ctrl.ram_addr),
      .wdata ({id_ff, seq_ff}),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         id_ff  <= req_sampler_id;
         seq_ff <= req_seq_number;
      end
   end

   // The read data still holds the matching entry during the update cycle.
   assign status.match    = (ram_rdata[ENTRY_W-1:DATA_W] == id_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign dropped         = seq_ff - ram_rdata[DATA_W-1:0] - DATA_W'(1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         dropped_ff <= ctrl.hit ? dropped : '0;
         new_ff     <= !ctrl.hit;
         full_ff    <= !ctrl.hit && ctrl.full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dropped_count = dropped_ff;
   assign rsp_new_sampler   = new_ff;
   assign rsp_table_full    = full_ff;

endmodule

// ===== hw/rtl/sgt_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ---------------------------------------------------------------------------
module sgt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                         wdata,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/sgt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sequence gap tracker sequencer
// Walks the filled part of the table one entry per cycle, tracks the fill
// count and steers the table update and the result load.
// ---------------------------------------------------------------------------
module sgt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sgt_pkg::sgt_status_type status,
   output sgt_pkg::sgt_ctrl_type   ctrl
);
   import sgt_pkg::*;

   sgt_state_type    state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             pend_ff, pend_in;
   logic             hit_ff, hit_in;
   logic             issue;
   logic             found;
   logic             full;

   // Entries are only ever appended, so the valid ones form a prefix.
   assign full  = (fill_ff == CNT_W'(TABLE_ENTRIES));
   assign issue = (scan_idx_ff < fill_ff);
   assign found = pend_ff && status.match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         scan_idx_ff <= '0;
         cmp_idx_ff  <= '0;
         pend_ff     <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         scan_idx_ff <= scan_idx_in;
         cmp_idx_ff  <= cmp_idx_in;
         pend_ff     <= pend_in;
         hit_ff      <= hit_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      pend_in       = pend_ff;
      hit_in        = hit_ff;
      req_ready     = 1'b0;
      ctrl.capture  = 1'b0;
      ctrl.ram_re   = 1'b0;
      ctrl.ram_we   = 1'b0;
      ctrl.ram_addr = scan_idx_ff[IDX_W-1:0];
      ctrl.load_out = 1'b0;
      ctrl.hit      = hit_ff;
      ctrl.full     = full;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               scan_idx_in  = '0;
               pend_in      = 1'b0;
               hit_in       = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The read issued here is compared in the following cycle.
            if (found) begin
               hit_in   = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_UPDATE;
            end else if (!issue) begin
               pend_in  = 1'b0;
               state_in = ST_UPDATE;
            end else begin
               ctrl.ram_re = 1'b1;
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
               pend_in     = 1'b1;
            end
         end
         ST_UPDATE: begin
            ctrl.ram_addr = hit_ff ? cmp_idx_ff : fill_ff[IDX_W-1:0];
            if (status.out_free) begin
               ctrl.load_out = 1'b1;
               ctrl.ram_we   = hit_ff || !full;
               if (!hit_ff && !full) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/sgt_checker.sv =====
// ---------------------------------------------------------------------------
// Sequence gap tracker checker
// Port-level properties of the tracker, attached to the top level by bind.
// ---------------------------------------------------------------------------
module sgt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sgt_pkg::DATA_W-1:0] rsp_dropped_count,
   input logic                       rsp_new_sampler,
   input logic                       rsp_table_full
);
   import sgt_pkg::*;

   // No response may survive a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A known sampler can never report a full table.
   a_full_only_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_new_sampler |-> !rsp_table_full)
      else $error("table full reported for a known sampler");

   // A new sampler always reports zero drops.
   a_new_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_sampler |-> rsp_dropped_count == '0)
      else $error("new sampler reported nonzero drops");

   // An accepted request moves the sequencer out of idle, so requests cannot be taken back to back.
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during a scan");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dropped_count)
         && $stable(rsp_new_sampler) && $stable(rsp_table_full))
      else $error("stalled response changed");

endmodule

bind sampler_sequence_gap_tracker sgt_checker u_sgt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_dropped_count (rsp_dropped_count),
   .rsp_new_sampler   (rsp_new_sampler),
   .rsp_table_full    (rsp_table_full)
);

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// Sampler sequence gap tracker testbench
// Drives sampler/sequence transactions through the tracker and compares every
// response against a behavioral table of last sequence numbers kept here:
// edge values, wraparound gaps, table fill and overflow, output back-pressure,
// and long random traffic with and without idle cycles on both channels.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sgt_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 2 * TABLE_ENTRIES + 8;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [DATA_W-1:0] dropped;
      logic              is_new;
      logic              full;
   } gap_report_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [DATA_W-1:0] req_sampler_id;
   logic [DATA_W-1:0] req_seq_number;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_dropped_count;
   logic              rsp_new_sampler;
   logic              rsp_table_full;

   // Shadow copy of the sampler table.
   bit                known_valid [TABLE_ENTRIES];
   logic [DATA_W-1:0] known_id    [TABLE_ENTRIES];
   logic [DATA_W-1:0] known_seq   [TABLE_ENTRIES];

   gap_report_type pending_reports[$];
   int             mismatch_count = 0;
   bit             idling_on      = 1'b1;
   int             hold_token     = 0;

   sampler_sequence_gap_tracker u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sampler_id    (req_sampler_id),
      .req_seq_number    (req_seq_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dropped_count (rsp_dropped_count),
      .rsp_new_sampler   (rsp_new_sampler),
      .rsp_table_full    (rsp_table_full)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Looks up the sampler, updates the shadow table and returns the report.
   function automatic gap_report_type track_sample(input logic [DATA_W-1:0] id,
                                                   input logic [DATA_W-1:0] seq);
      gap_report_type r;
      int             free_idx;
      bit             hit;
      r.dropped = '0;
      r.is_new  = 1'b1;
      r.full    = 1'b0;
      free_idx  = -1;
      hit       = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (known_valid[i]) begin
            if (!hit && known_id[i] == id) begin
               hit          = 1'b1;
               r.dropped    = seq - known_seq[i] - 32'd1;
               r.is_new     = 1'b0;
               known_seq[i] = seq;
            end
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (!hit) begin
         if (free_idx >= 0) begin
            known_valid[free_idx] = 1'b1;
            known_id[free_idx]    = id;
            known_seq[free_idx]   = seq;
         end else begin
            r.full = 1'b1;
         end
      end
      return r;
   endfunction

   // Called and returns at a falling edge; valid stays high after acceptance
   // until the next call either offers another transaction or idles.
   task automatic send_sample(input logic [DATA_W-1:0] id, input logic [DATA_W-1:0] seq);
      while (idling_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_sampler_id <= id;
      req_seq_number <= seq;
      do
         @(posedge clock);
      while (!req_ready);
      pending_reports.push_back(track_sample(id, seq));
      @(negedge clock);
   endtask

   // Response checker.
   initial begin
      gap_report_type want;
      gap_report_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.dropped = rsp_dropped_count;
            got.is_new  = rsp_new_sampler;
            got.full    = rsp_table_full;
            if (pending_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("ERROR: unexpected response dropped=%h new=%b full=%b",
                           got.dropped, got.is_new, got.full);
            end else begin
               want = pending_reports.pop_front();
               if (got.dropped !== want.dropped || got.is_new !== want.is_new ||
                   got.full !== want.full) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"ERROR: expected dropped=%h new=%b full=%b, ",
                               "got dropped=%h new=%b full=%b"},
                              want.dropped, want.is_new, want.full,
                              got.dropped, got.is_new, got.full);
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever a test asks.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idling_on && $urandom_range(99) < 17);
         end
      end
   end

   // Ends the run when no transaction moves on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", quiet_cycles);
            $display("sampler_sequence_gap_tracker regression: fail");
            $finish;
         end
      end
   end

   task automatic test_sequence_gaps();
      send_sample(32'h0000_0000, 32'hFFFF_FFFF);   // new sampler
      send_sample(32'h0000_0000, 32'h0000_0000);   // wraps to a gap of zero
      send_sample(32'h0000_0000, 32'h0000_0000);   // repeated number
      send_sample(32'hFFFF_FFFF, 32'h0000_0000);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // largest forward gap
      send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'h7FFF_FFF0);   // older number
   endtask

   task automatic test_table_fill();
      logic [DATA_W-1:0] id;
      for (int k = 0; k < TABLE_ENTRIES - 2; k++) begin
         id = k[0] ? (32'h5555_5500 + k) : (32'hAAAA_AA00 + k);
         send_sample(id, $urandom);
      end
      // The table is now full, so further new samplers are not stored.
      send_sample(32'h1234_5678, 32'h0000_0000);
      send_sample(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_sample(known_id[TABLE_ENTRIES-1], known_seq[TABLE_ENTRIES-1] + 32'd1);
   endtask

   // Mostly well-formed sequences on stored samplers, with jumps, repeats,
   // older numbers, unknown samplers and one-bit near misses mixed in.
   task automatic test_random_traffic(input int count);
      logic [DATA_W-1:0] id;
      logic [DATA_W-1:0] seq;
      int                idx;
      int                pick;
      repeat (count) begin
         pick = $urandom_range(99);
         idx  = $urandom_range(TABLE_ENTRIES - 1);
         id   = known_valid[idx] ? known_id[idx] : $urandom;
         seq  = known_seq[idx];
         if (pick < 65) begin
            seq = seq + 32'd1 + (($urandom_range(3) == 0) ? $urandom_range(9) : 0);
         end else if (pick < 72) begin
            seq = seq;
         end else if (pick < 78) begin
            seq = seq - $urandom_range(1, 1000);
         end else if (pick < 86) begin
            seq = $urandom;
         end else if (pick < 93) begin
            id  = $urandom;
            seq = $urandom;
         end else begin
            id  = id ^ (32'h1 << $urandom_range(31));
            seq = $urandom;
         end
         send_sample(id, seq);
      end
   endtask

   // The receiver stops long enough for the output register to fill and
   // the request side to stall while items keep being offered.
   task automatic test_output_backpressure();
      hold_token++;
      test_random_traffic(60);
   endtask

   task automatic test_streaming_no_idle();
      idling_on = 1'b0;
      test_random_traffic(480);
      idling_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sampler_id = '0;
      req_seq_number = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         known_valid[i] = 1'b0;
         known_id[i]    = '0;
         known_seq[i]   = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_sequence_gaps();
      test_table_fill();
      test_output_backpressure();
      test_random_traffic(1400);
      test_streaming_no_idle();

      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("sampler_sequence_gap_tracker regression: pass");
      end else begin
         $display("sampler_sequence_gap_tracker regression: fail");
      end
      $finish;
   end

endmodule
